// File: hdl/pht_pkg.sv
// ----------------------------------------------------------------------------
// pht_pkg: shared types and constants for the probed hash table
// Holds table sizes, control byte codes, filter multipliers, opcodes, status codes and states.
// ----------------------------------------------------------------------------
`default_nettype none
package pht_pkg;
  localparam int TableSlots = 1024;
  localparam int ProbeGroup = 16;
  localparam int FilterBits = 16384;
  localparam int KeyBytes   = 8;
  localparam int SlotW      = $clog2(TableSlots);
  localparam int FiltW      = $clog2(FilterBits);
  localparam int ProbeSteps = ((TableSlots + ProbeGroup - 1) / ProbeGroup) * ProbeGroup;
  localparam int StepW      = $clog2(ProbeSteps + 1);
  localparam int CountW     = 11;

  localparam logic [7:0]  CtrlEmpty = 8'h80;
  localparam logic [7:0]  CtrlTomb  = 8'hFE;
  localparam logic [31:0] BloomMulA = 32'h9e3779b9;
  localparam logic [31:0] BloomMulB = 32'h517cc1b7;

  typedef enum logic [1:0] {
    OP_FIND = 2'd0, OP_SET = 2'd1, OP_DEL = 2'd2, OP_NOP = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_MISS = 2'd1, ST_BADKEY = 2'd2, ST_FULL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_BLOOM_A, S_BLOOM_B, S_BLOOM_CHK, S_READ, S_WAIT, S_CHECK,
    S_INS_A, S_INS_B, S_DONE
  } state_t;
endpackage
`default_nettype wire

// File: hdl/probed_hash_table_with_bloom.sv
// ----------------------------------------------------------------------------
// probed_hash_table_with_bloom: open-addressed key table with a Bloom filter
// Linear probing over 1-byte control slots, two-hash filter on find and delete.
// ----------------------------------------------------------------------------
// Pulse start while busy is low; the command transfers on that edge and busy
// rises. One result shows for exactly one cycle with done high; the receiver
// cannot stall it. Opcode 3, or a set or delete with a bad key length, goes
// straight to its result. A find or delete first reads the filter and ends
// there if the filter rejects it; a set skips the filter. The command then
// probes slots (up to 1024) until a match, an empty slot or a full pass, and
// a set that inserts then writes its two filter bits. Every probe step is a
// registered read of the slot memories followed by one shared compare, and
// the filter costs two reads of its memory. The next command can transfer at
// the edge that ends the done cycle. After reset the control bytes and filter
// are cleared by a sweep over all 16384 filter bits (one filter bit and, while
// the index is below 1024, one control byte per cycle) with busy held high.
`default_nettype none
module probed_hash_table_with_bloom (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] hash_value,
  input  wire logic [63:0] key_bytes,
  input  wire logic [3:0]  key_len,
  input  wire logic [63:0] value_word,
  input  wire logic [3:0]  value_len,
  output logic             done,
  output logic [1:0]       status,
  output logic [63:0]      found_value,
  output logic [3:0]       found_value_len,
  output logic [10:0]      entry_count,
  output logic [10:0]      tombstone_count,
  output logic [31:0]      hit_count,
  output logic [31:0]      miss_count
);
  import pht_pkg::*;

  // slot stores
  logic [7:0]  ctrl_mem  [TableSlots];
  logic [31:0] hash_mem  [TableSlots];
  logic [63:0] key_mem   [TableSlots];
  logic [3:0]  klen_mem  [TableSlots];
  logic [63:0] val_mem   [TableSlots];
  logic [3:0]  vlen_mem  [TableSlots];
  logic        bloom_mem [FilterBits];

  state_t state, state_next;
  logic clearing;
  logic [FiltW-1:0] clr_idx;

  // latched command
  opcode_t op;
  logic [31:0] h;
  logic [63:0] key, val;
  logic [3:0]  kl, vl;
  logic [SlotW-1:0] idx;
  logic [StepW-1:0] step;
  logic have_tomb;
  logic [SlotW-1:0] tomb;
  logic bloom_a_hit;
  logic [FiltW-1:0] pos_a, pos_b;

  // registered reads
  logic [7:0]  rd_ctrl;
  logic [31:0] rd_hash;
  logic [63:0] rd_key, rd_val;
  logic [3:0]  rd_klen, rd_vlen;
  logic        rd_bloom;
  logic [FiltW-1:0] bloom_raddr;

  logic [10:0] live, tombs;
  logic [31:0] hits, misses;

  // result registers
  logic [1:0]  res_status;
  logic [63:0] res_val;
  logic [3:0]  res_vlen;

  // decoded write requests
  logic        ctrl_we, slot_we, val_we, bloom_we;
  logic [SlotW-1:0] wr_idx;
  logic [7:0]  ctrl_wd;
  logic [FiltW-1:0] bloom_waddr;

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < n) m[b*8 +: 8] = 8'hFF;
    end
    return m;
  endfunction

  logic key_ok;
  logic [6:0] fp;
  logic slot_match;
  logic [31:0] mul_a, mul_b;
  assign key_ok = (kl != 4'd0) && (kl <= 4'(KeyBytes));
  assign fp = h[6:0];
  assign mul_a = h * BloomMulA;
  assign mul_b = {16'd0, h[31:16]} * BloomMulB;
  assign slot_match = (rd_ctrl == {1'b0, fp}) && (rd_hash == h) &&
                      (rd_klen == kl) && (rd_key == key);

  // the first filter address comes straight from the product; it is
  // registered into pos_a on the same edge
  always_comb begin
    bloom_raddr = (state == S_BLOOM_A) ? mul_a[FiltW-1:0] : pos_b;
  end

  // memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (clearing) begin
      bloom_mem[clr_idx] <= 1'b0;
      if (clr_idx < FiltW'(TableSlots)) ctrl_mem[clr_idx[SlotW-1:0]] <= CtrlEmpty;
    end else begin
      if (ctrl_we) ctrl_mem[wr_idx] <= ctrl_wd;
      if (bloom_we) bloom_mem[bloom_waddr] <= 1'b1;
    end
    if (slot_we) begin
      hash_mem[wr_idx] <= (op == OP_SET) ? h : 32'd0;
      key_mem[wr_idx]  <= (op == OP_SET) ? key : 64'd0;
      klen_mem[wr_idx] <= (op == OP_SET) ? kl : 4'd0;
    end
    if (val_we) begin
      val_mem[wr_idx]  <= (op == OP_SET) ? val : 64'd0;
      vlen_mem[wr_idx] <= (op == OP_SET) ? vl : 4'd0;
    end
    rd_ctrl  <= ctrl_mem[idx];
    rd_hash  <= hash_mem[idx];
    rd_key   <= key_mem[idx];
    rd_klen  <= klen_mem[idx];
    rd_val   <= val_mem[idx];
    rd_vlen  <= vlen_mem[idx];
    rd_bloom <= bloom_mem[bloom_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // next state and write decode
  always_comb begin
    state_next = state;
    ctrl_we = 1'b0; slot_we = 1'b0; val_we = 1'b0; bloom_we = 1'b0;
    wr_idx = idx; ctrl_wd = CtrlTomb; bloom_waddr = pos_a;
    unique case (state)
      S_IDLE: if (start && !clearing) state_next = S_BLOOM_A;
      S_BLOOM_A: begin
        if (op == OP_NOP || (op != OP_FIND && !key_ok)) state_next = S_DONE;
        else if (op == OP_SET) state_next = S_READ;
        else state_next = S_BLOOM_B;
      end
      S_BLOOM_B: state_next = S_BLOOM_CHK;
      S_BLOOM_CHK: state_next = (bloom_a_hit && rd_bloom) ? S_READ : S_DONE;
      S_READ: state_next = S_WAIT;
      S_WAIT: state_next = S_CHECK;
      S_CHECK: begin
        if (rd_ctrl == CtrlEmpty) begin
          if (op == OP_SET) begin
            state_next = S_INS_A;
            wr_idx = have_tomb ? tomb : idx;
            ctrl_we = 1'b1; ctrl_wd = {1'b0, fp};
            slot_we = 1'b1; val_we = 1'b1;
          end else begin
            state_next = S_DONE;
          end
        end else if (slot_match) begin
          state_next = S_DONE;
          if (op == OP_SET) val_we = 1'b1;
          else if (op == OP_DEL) begin
            ctrl_we = 1'b1; slot_we = 1'b1; val_we = 1'b1;
          end
        end else if (step == StepW'(ProbeSteps - 1)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_WAIT;
        end
      end
      S_INS_A: begin
        bloom_we = 1'b1; bloom_waddr = pos_a; state_next = S_INS_B;
      end
      S_INS_B: begin
        bloom_we = 1'b1; bloom_waddr = pos_b; state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx <= '0;
      live <= '0; tombs <= '0; hits <= '0; misses <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == FiltW'(FilterBits - 1)) clearing <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (start && !clearing) begin
          op <= opcode_t'(opcode);
          h <= hash_value;
          key <= key_bytes & byte_mask(key_len);
          kl <= key_len;
          vl <= (value_len > 4'd8) ? 4'd8 : value_len;
          val <= value_word & byte_mask((value_len > 4'd8) ? 4'd8 : value_len);
          idx <= hash_value[SlotW+6:7];
          step <= '0;
          have_tomb <= 1'b0;
          res_status <= ST_MISS; res_val <= '0; res_vlen <= '0;
        end
        S_BLOOM_A: begin
          pos_a <= mul_a[FiltW-1:0];
          pos_b <= mul_b[FiltW-1:0];
          if (op == OP_NOP) res_status <= ST_OK;
          else if (op != OP_FIND && !key_ok) res_status <= ST_BADKEY;
          else if (op == OP_SET) res_status <= ST_FULL;
        end
        S_BLOOM_B: ;
        S_BLOOM_CHK: bloom_a_hit <= 1'b0;
        S_READ: ;
        S_WAIT: ;
        S_CHECK: begin
          if (rd_ctrl == CtrlEmpty) begin
            if (op == OP_SET) begin
              res_status <= ST_OK;
              live <= live + 1'b1;
              if (have_tomb) tombs <= tombs - 1'b1;
            end
          end else if (slot_match) begin
            res_status <= ST_OK;
            if (op == OP_FIND) begin
              res_val <= rd_val; res_vlen <= rd_vlen;
            end else if (op == OP_DEL) begin
              live <= live - 1'b1; tombs <= tombs + 1'b1;
            end
          end else begin
            if (rd_ctrl == CtrlTomb && !have_tomb) begin
              have_tomb <= 1'b1; tomb <= idx;
            end
            step <= step + 1'b1;
            idx <= idx + 1'b1;
          end
        end
        S_INS_A: ;
        S_INS_B: ;
        S_DONE: if (op == OP_FIND) begin
          if (res_status == ST_OK) hits <= hits + 1'b1;
          else misses <= misses + 1'b1;
        end
        default: ;
      endcase
      // first filter bit is valid in the cycle after its read address was given
      if (state == S_BLOOM_B) bloom_a_hit <= rd_bloom;
    end
  end

  assign busy = clearing || (state != S_IDLE);
  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      status <= res_status;
      found_value <= res_val;
      found_value_len <= res_vlen;
      entry_count <= live;
      tombstone_count <= tombs;
      hit_count <= (op == OP_FIND && res_status == ST_OK) ? hits + 1'b1 : hits;
      miss_count <= (op == OP_FIND && res_status != ST_OK) ? misses + 1'b1 : misses;
    end
  end

  // the table can never hold more live entries plus tombstones than slots
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (11'(live) + 11'(tombs)) <= 11'(TableSlots))
    else $error("slot accounting exceeds table size");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_no_start_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |=> state == S_IDLE) else $error("command accepted during clear");
  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> step < StepW'(ProbeSteps)) else $error("probe overran a pass");
endmodule
`default_nettype wire

// File: tb/sv/probed_hash_table_with_bloom_chk.sv
// ----------------------------------------------------------------------------
// probed_hash_table_with_bloom_chk: result checker for the probed hash table
// Watches command and result transfers, keeps its own copy of the table and
// filter, and compares every result field with the predicted one.
// ----------------------------------------------------------------------------
`default_nettype none
module probed_hash_table_with_bloom_chk (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] hash_value,
  input  wire logic [63:0] key_bytes,
  input  wire logic [3:0]  key_len,
  input  wire logic [63:0] value_word,
  input  wire logic [3:0]  value_len,
  input  wire logic        done,
  input  wire logic [1:0]  status,
  input  wire logic [63:0] found_value,
  input  wire logic [3:0]  found_value_len,
  input  wire logic [10:0] entry_count,
  input  wire logic [10:0] tombstone_count,
  input  wire logic [31:0] hit_count,
  input  wire logic [31:0] miss_count,
  output int               fails,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pht_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [63:0] value;
    logic [3:0]  value_len;
    logic [10:0] entries;
    logic [10:0] tombs;
    logic [31:0] hits;
    logic [31:0] misses;
  } table_result_t;

  logic [7:0]  ctrl      [TableSlots];
  logic [31:0] tbl_hash  [TableSlots];
  logic [63:0] tbl_key   [TableSlots];
  logic [3:0]  tbl_klen  [TableSlots];
  logic [63:0] tbl_val   [TableSlots];
  logic [3:0]  tbl_vlen  [TableSlots];
  logic        filter    [FilterBits];
  logic [10:0] live_cnt, tomb_cnt;
  logic [31:0] hit_cnt, miss_cnt;

  table_result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [63:0] low_bytes(input logic [3:0] n);
    if (n >= 8) return '1;
    return (64'd1 << (n * 8)) - 64'd1;
  endfunction

  function automatic logic [FiltW-1:0] filter_pos_a(input logic [31:0] h);
    logic [31:0] p;
    p = h * BloomMulA;
    return p[FiltW-1:0];
  endfunction

  function automatic logic [FiltW-1:0] filter_pos_b(input logic [31:0] h);
    logic [31:0] p;
    p = (h >> 16) * BloomMulB;
    return p[FiltW-1:0];
  endfunction

  // Apply one command to the shadow table and return the result it gives.
  task automatic apply_command(input logic [1:0] op, input logic [31:0] h,
                               input logic [63:0] kin, input logic [3:0] kl,
                               input logic [63:0] vin, input logic [3:0] vlin,
                               output table_result_t r);
    logic [63:0]      key, v;
    logic [3:0]       vl;
    logic [7:0]       fp;
    logic [SlotW-1:0] idx, si, tomb_slot, empty_slot;
    logic             key_ok, maybe, have_tomb, have_empty, matched;
    key        = kin & low_bytes(kl);
    vl         = (vlin > 8) ? 4'd8 : vlin;
    v          = vin & low_bytes(vl);
    fp         = {1'b0, h[6:0]};
    idx        = h[SlotW+6:7];
    key_ok     = kl != 0 && kl <= KeyBytes;
    maybe      = filter[filter_pos_a(h)] && filter[filter_pos_b(h)];
    have_tomb  = 1'b0;
    have_empty = 1'b0;
    matched    = 1'b0;
    tomb_slot  = '0;
    empty_slot = '0;
    r          = '0;
    r.status   = ST_OK;
    case (opcode_t'(op))
      OP_FIND: begin
        r.status = ST_MISS;
        if (maybe) begin
          for (int i = 0; i < ProbeSteps; i++) begin
            si = idx + SlotW'(i);
            if (ctrl[si] == CtrlEmpty) break;
            if (ctrl[si] == fp && tbl_hash[si] == h && tbl_klen[si] == kl &&
                tbl_key[si] == key) begin
              r.status    = ST_OK;
              r.value     = tbl_val[si];
              r.value_len = tbl_vlen[si];
              break;
            end
          end
        end
        if (r.status == ST_OK) hit_cnt++;
        else miss_cnt++;
      end
      OP_SET: begin
        if (!key_ok) begin
          r.status = ST_BADKEY;
        end else begin
          r.status = ST_FULL;
          for (int i = 0; i < ProbeSteps; i++) begin
            si = idx + SlotW'(i);
            if (ctrl[si] == CtrlEmpty) begin
              have_empty = 1'b1;
              empty_slot = si;
              break;
            end
            if (ctrl[si] == CtrlTomb) begin
              if (!have_tomb) begin
                have_tomb = 1'b1;
                tomb_slot = si;
              end
              continue;
            end
            if (ctrl[si] == fp && tbl_hash[si] == h && tbl_klen[si] == kl &&
                tbl_key[si] == key) begin
              tbl_val[si]  = v;
              tbl_vlen[si] = vl;
              matched      = 1'b1;
              break;
            end
          end
          if (matched) begin
            r.status = ST_OK;
          end else if (have_empty) begin
            si = have_tomb ? tomb_slot : empty_slot;
            if (have_tomb) tomb_cnt--;
            ctrl[si]     = fp;
            tbl_hash[si] = h;
            tbl_key[si]  = key;
            tbl_klen[si] = kl;
            tbl_val[si]  = v;
            tbl_vlen[si] = vl;
            filter[filter_pos_a(h)] = 1'b1;
            filter[filter_pos_b(h)] = 1'b1;
            live_cnt++;
            r.status = ST_OK;
          end
        end
      end
      OP_DEL: begin
        if (!key_ok) begin
          r.status = ST_BADKEY;
        end else begin
          r.status = ST_MISS;
          if (maybe) begin
            for (int i = 0; i < ProbeSteps; i++) begin
              si = idx + SlotW'(i);
              if (ctrl[si] == CtrlEmpty) break;
              if (ctrl[si] == fp && tbl_hash[si] == h && tbl_klen[si] == kl &&
                  tbl_key[si] == key) begin
                ctrl[si] = CtrlTomb;
                live_cnt--;
                tomb_cnt++;
                r.status = ST_OK;
                break;
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.entries = live_cnt;
    r.tombs   = tomb_cnt;
    r.hits    = hit_cnt;
    r.misses  = miss_cnt;
  endtask

  task automatic report(input string field, input logic [63:0] got,
                        input logic [63:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, field, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    table_result_t exp_r, new_r;
    if (rst) begin
      for (int i = 0; i < TableSlots; i++) ctrl[i] = CtrlEmpty;
      for (int i = 0; i < FilterBits; i++) filter[i] = 1'b0;
      live_cnt = '0;
      tomb_cnt = '0;
      hit_cnt  = '0;
      miss_cnt = '0;
      fails    = 0;
      expected_results.delete();
    end else begin
      // Compare first: a result that shows at the same edge as a new command
      // belongs to an older one.
      if (done) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", 64'(status), 64'd0);
        end else begin
          exp_r = expected_results.pop_front();
          if (status != exp_r.status)
            report("status", 64'(status), 64'(exp_r.status));
          if (found_value != exp_r.value) report("found_value", found_value, exp_r.value);
          if (found_value_len != exp_r.value_len)
            report("found_value_len", 64'(found_value_len), 64'(exp_r.value_len));
          if (entry_count != exp_r.entries)
            report("entry_count", 64'(entry_count), 64'(exp_r.entries));
          if (tombstone_count != exp_r.tombs)
            report("tombstone_count", 64'(tombstone_count), 64'(exp_r.tombs));
          if (hit_count != exp_r.hits)
            report("hit_count", 64'(hit_count), 64'(exp_r.hits));
          if (miss_count != exp_r.misses)
            report("miss_count", 64'(miss_count), 64'(exp_r.misses));
        end
      end
      if (start && !busy) begin
        apply_command(opcode, hash_value, key_bytes, key_len, value_word, value_len, new_r);
        expected_results.push_back(new_r);
      end
    end
  end
endmodule
`default_nettype wire

// File: tb/sv/probed_hash_table_with_bloom_tb.sv
// ----------------------------------------------------------------------------
// probed_hash_table_with_bloom_tb: regression for the probed hash table
// Directed corner commands, then clustered random traffic over a key pool;
// results go to the checker.
// ----------------------------------------------------------------------------
`default_nettype none
module probed_hash_table_with_bloom_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pht_pkg::*;

  logic        clk = 1'b0;
  logic        rst, start, busy, done;
  logic [1:0]  opcode, status;
  logic [31:0] hash_value, hit_count, miss_count;
  logic [63:0] key_bytes, value_word, found_value;
  logic [3:0]  key_len, value_len, found_value_len;
  logic [10:0] entry_count, tombstone_count;
  int          fails, pending;
  bit          no_idle;

  localparam int PoolSize = 40;
  logic [31:0] pool_hash [PoolSize];
  logic [63:0] pool_key  [PoolSize];
  logic [3:0]  pool_klen [PoolSize];

  probed_hash_table_with_bloom uut (.*);

  probed_hash_table_with_bloom_chk chk (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hold off for a random gap (none during a burst), then present one command
  // and hold it until the transfer edge. Returns right after that edge.
  task automatic issue(input opcode_t op, input logic [31:0] h, input logic [63:0] k,
                       input logic [3:0] kl, input logic [63:0] v, input logic [3:0] vl);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    opcode     <= op;
    hash_value <= h;
    key_bytes  <= k;
    key_len    <= kl;
    value_word <= v;
    value_len  <= vl;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  initial begin
    logic [31:0] h;
    int          p, roll;
    start      <= 1'b0;
    opcode     <= OP_FIND;
    hash_value <= 32'd1;
    key_bytes  <= '0;
    key_len    <= '0;
    value_word <= '0;
    value_len  <= '0;
    no_idle    = 1'b0;
    rst        <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed corners: empty table, overwrite, saturation, collisions, wrap.
    issue(OP_FIND, 32'h0001_2345, 64'h11, 4'd1, '0, 4'd0);                 // filter miss
    issue(OP_SET,  32'h0001_2345, '1, 4'd8, '1, 4'd8);
    issue(OP_SET,  32'h0001_2345, '1, 4'd8, 64'h0123_4567_89ab_cdef, 4'd15); // overwrite
    issue(OP_FIND, 32'h0001_2345, '1, 4'd8, '0, 4'd0);                      // hit
    issue(OP_SET,  32'h0001_2345, 64'hdead_beef_0000_00aa, 4'd1, '1, 4'd3); // same hash, new key
    issue(OP_FIND, 32'h0001_2345, 64'h5555_5555_5555_55aa, 4'd1, '0, 4'd0); // junk upper bytes
    issue(OP_SET,  32'hffff_ff45, 64'h0, 4'd4, 64'h77, 4'd0);               // same fingerprint
    issue(OP_FIND, 32'h0001_2345, 64'h0, 4'd0, '0, 4'd0);                   // zero length find
    issue(OP_SET,  32'h0001_2345, 64'h0, 4'd0, '1, 4'd8);                   // rejected set
    issue(OP_DEL,  32'h0001_2345, 64'h0, 4'd0, '0, 4'd0);                   // rejected delete
    issue(OP_DEL,  32'h0000_0001, 64'h1, 4'd2, '0, 4'd0);                   // delete miss
    issue(OP_DEL,  32'h0001_2345, '1, 4'd8, '0, 4'd0);                      // tombstone
    issue(OP_FIND, 32'h0001_2345, '1, 4'd8, '0, 4'd0);                      // miss over tomb
    issue(OP_FIND, 32'h0001_2345, 64'haa, 4'd1, '0, 4'd0);                  // hit past tomb
    issue(OP_SET,  32'h0001_2345, 64'h42, 4'd2, 64'h1234, 4'd2);            // reuse tomb
    issue(OP_NOP,  32'hffff_ffff, '1, 4'd15, '1, 4'd15);
    issue(OP_SET,  32'h0001_ff80, 64'h1, 4'd1, 64'h1, 4'd1);                // slot 1023
    issue(OP_SET,  32'h0001_ff80, 64'h2, 4'd1, 64'h2, 4'd1);                // wraps to 0
    issue(OP_FIND, 32'h0001_ff80, 64'h2, 4'd1, '0, 4'd0);
    issue(OP_DEL,  32'h0001_ff80, 64'h1, 4'd1, '0, 4'd0);
    issue(OP_FIND, 32'h0001_ff80, 64'h2, 4'd1, '0, 4'd0);
    issue(OP_FIND, 32'hffff_ffff, '1, 4'd8, '0, 4'd0);

    // Key pool packed into a few start slots with few fingerprints, so
    // probes run through collisions, tombstones and wrap.
    for (int i = 0; i < PoolSize; i++) begin
      h = $urandom();
      h[16:7] = (i % 5 == 4) ? 10'd1022 + 10'($urandom_range(0, 2)) : 10'($urandom_range(0, 6) * 3);
      h[6:0]  = 7'($urandom_range(0, 3));
      if (i % 4 == 3) h = pool_hash[i - 1];
      if (h == 0) h = 32'd1;
      pool_hash[i] = h;
      pool_key[i]  = {$urandom(), $urandom()};
      pool_klen[i] = 4'($urandom_range(1, 8));
    end

    for (int n = 0; n < 820; n++) begin
      if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        p = $urandom_range(0, PoolSize - 1);
        roll = $urandom_range(0, 99);
        // Upper key bytes beyond the length carry junk on purpose.
        issue(roll < 40 ? OP_FIND : (roll < 75 ? OP_SET : OP_DEL), pool_hash[p],
              pool_key[p] ^ ({$urandom(), $urandom()} & ~((64'd1 << (pool_klen[p] * 8)) - 1)
                             & {64{pool_klen[p] != 8}}),
              pool_klen[p], {$urandom(), $urandom()}, 4'($urandom_range(0, 8)));
      end else begin
        h = $urandom();
        if (h == 0) h = 32'd1;
        issue(opcode_t'($urandom_range(0, 3)), h, {$urandom(), $urandom()},
              4'($urandom_range(0, 8)), {$urandom(), $urandom()}, 4'($urandom_range(0, 8)));
      end
    end
    no_idle = 1'b0;

    // A few closing commands on the loaded table.
    issue(OP_SET, 32'h8000_0011, 64'h99, 4'd1, 64'h5, 4'd1);
    issue(OP_FIND, 32'h8000_0011, 64'h99, 4'd1, '0, 4'd0);
    issue(OP_DEL, {5'h1f, 10'd7, 10'd7, 7'd0}, 64'd7, 4'd2, '0, 4'd0);
    issue(OP_SET, 32'h8000_0011, 64'h99, 4'd1, 64'h5, 4'd1);
    issue(OP_FIND, pool_hash[0], pool_key[0], pool_klen[0], '0, 4'd0);
    start <= 1'b0;

    // Let the checker log the last transfer before waiting on it.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("probed_hash_table_with_bloom regression: pass");
    end else begin
      $display("probed_hash_table_with_bloom regression: fail");
    end
    $finish;
  end

  // Drop the run if it hangs; covers the clearing sweep and full-pass scans.
  initial begin
    #200ms;
    $display("probed_hash_table_with_bloom regression: fail");
    $finish;
  end
endmodule
`default_nettype wire
